// ===== rtl/core/metd_pkg.sv =====
// ----------------------------------------------------------------------------
// metd_pkg: shared types and constants for the Morse edge timing decoder
// Holds the queue entry format, back-end states and the code lookup.
// ----------------------------------------------------------------------------
package metd_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned UnitW     = 10;
  localparam int unsigned CharW     = 7;
  localparam int unsigned ElemW     = 5;
  localparam int unsigned ElemCntW  = 3;
  localparam int unsigned StepW     = 5;

  localparam logic [UnitW-1:0]    UnitReset = 10'd100;
  localparam logic [UnitW-1:0]    UnitMin   = 10'd1;
  localparam logic [UnitW-1:0]    UnitMax   = 10'd1000;
  localparam logic [ElemCntW-1:0] MaxElems  = 3'd5;
  localparam logic [CharW-1:0]    AsciiSpace = 7'h20;
  localparam logic [CharW-1:0]    NoChar     = 7'h00;

  // one edge handed from front to back
  typedef struct packed {
    logic [TimeW-1:0] elapsed;
    logic             level;
  } edge_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DECIDE,
    ST_SEND
  } back_state_t;

  // index is (1 << count) | element bits, dash = 1
  function automatic logic [CharW-1:0] morse_lookup(input logic [5:0] idx);
    logic [CharW-1:0] ch;
    unique case (idx)
      6'd6:  ch = 7'h41; // A
      6'd17: ch = 7'h42;
      6'd21: ch = 7'h43;
      6'd9:  ch = 7'h44;
      6'd2:  ch = 7'h45;
      6'd20: ch = 7'h46;
      6'd11: ch = 7'h47;
      6'd16: ch = 7'h48;
      6'd4:  ch = 7'h49;
      6'd30: ch = 7'h4A;
      6'd13: ch = 7'h4B;
      6'd18: ch = 7'h4C;
      6'd7:  ch = 7'h4D;
      6'd5:  ch = 7'h4E;
      6'd15: ch = 7'h4F;
      6'd22: ch = 7'h50;
      6'd27: ch = 7'h51;
      6'd10: ch = 7'h52;
      6'd8:  ch = 7'h53;
      6'd3:  ch = 7'h54;
      6'd12: ch = 7'h55;
      6'd24: ch = 7'h56;
      6'd14: ch = 7'h57;
      6'd25: ch = 7'h58;
      6'd29: ch = 7'h59;
      6'd19: ch = 7'h5A; // Z
      6'd62: ch = 7'h31;
      6'd60: ch = 7'h32;
      6'd56: ch = 7'h33;
      6'd48: ch = 7'h34;
      6'd32: ch = 7'h35;
      6'd33: ch = 7'h36;
      6'd35: ch = 7'h37;
      6'd39: ch = 7'h38;
      6'd47: ch = 7'h39;
      6'd63: ch = 7'h30;
      default: ch = NoChar;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/core/morse_edge_timing_decoder.sv =====
// ----------------------------------------------------------------------------
// morse_edge_timing_decoder: Morse decoder from edge timestamps
// Measures mark and gap lengths in unit periods and emits ASCII letters,
// digits and word spaces.
//
//   port group   dir   contents
//   s_*          in    edge request: tdata[31:0] time_ms, tdata[32] level
//   m_*          out   result: tdata[6:0] character, tlast last
//   cfg_*        in    unit_period_ms write, 1..1000, others ignored
//
// An edge request is taken into a short queue; the decoding time per edge
// is set by the bit-serial 32-step divider.
// Reset is synchronous; unit period returns to 100 ms, pattern state clears.
// s_tready falls only when the queue is full; the result register holds
// while m_tready is low, and the decoder then waits in its send step.
// ----------------------------------------------------------------------------
module morse_edge_timing_decoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,     // [31:0] time_ms, [32] level
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,     // [6:0] character
  output logic        m_tlast,
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data
);

  logic            push_valid;
  logic            push_ready;
  metd_pkg::edge_t push_data;
  logic            q_valid;
  logic            q_pop;
  metd_pkg::edge_t q_data;

  metd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  metd_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_data   (push_data),
    .out_valid (q_valid),
    .out_ready (q_pop),
    .out_data  (q_data)
  );

  metd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_data      (q_data),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

endmodule

// ===== rtl/core/metd_front.sv =====
// ----------------------------------------------------------------------------
// metd_front: edge intake
// Accepts edge requests, tracks the previous timestamp and forwards the
// elapsed time with the sampled level. The first edge only sets the base.
// ----------------------------------------------------------------------------
module metd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [39:0]                   s_tdata,
  output logic                          push_valid,
  input  logic                          push_ready,
  output metd_pkg::edge_t               push_data
);

  logic [metd_pkg::TimeW-1:0] previous_time;
  logic                       seen_first_edge;
  logic [metd_pkg::TimeW-1:0] now;
  logic                       accept;

  assign now        = s_tdata[31:0];
  assign s_tready   = push_ready;
  assign accept     = s_tvalid & push_ready;
  assign push_valid = s_tvalid & seen_first_edge;

  assign push_data.elapsed = now - previous_time;
  assign push_data.level   = s_tdata[32];

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_time   <= '0;
      seen_first_edge <= 1'b0;
    end else if (accept) begin
      previous_time   <= now;
      seen_first_edge <= 1'b1;
    end
  end

endmodule

// ===== rtl/core/metd_fifo.sv =====
// ----------------------------------------------------------------------------
// metd_fifo: edge queue
// Short register queue between intake and decode.
// ----------------------------------------------------------------------------
module metd_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  metd_pkg::edge_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output metd_pkg::edge_t out_data
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  metd_pkg::edge_t entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  assign in_ready  = (count != Full);
  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign push      = in_valid & in_ready;
  assign pop       = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/metd_back.sv =====
// ----------------------------------------------------------------------------
// metd_back: timing decode
// Divides elapsed time by the unit period one quotient bit per cycle,
// builds the dot/dash pattern and emits letters and spaces.
// ----------------------------------------------------------------------------
module metd_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [metd_pkg::UnitW-1:0]   cfg_wr_data,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  metd_pkg::edge_t              q_data,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [7:0]                   m_tdata,
  output logic                         m_tlast
);

  metd_pkg::back_state_t state, state_next;

  logic [metd_pkg::UnitW-1:0]    unit_period_ms;
  logic [metd_pkg::TimeW-1:0]    dvd;
  logic [metd_pkg::UnitW-1:0]    rem;
  logic [metd_pkg::StepW-1:0]    step;
  logic                          level;
  logic [metd_pkg::ElemW-1:0]    element_bits;
  logic [metd_pkg::ElemCntW-1:0] element_count;
  logic                          pattern_overflow;
  logic [metd_pkg::CharW-1:0]    pend_char;
  logic                          pend_space;

  logic [metd_pkg::UnitW:0]      trial;
  logic                          qbit;
  logic [metd_pkg::UnitW:0]      trial_diff;
  logic [5:0]                    code_idx;
  logic [metd_pkg::CharW-1:0]    letter;
  logic                          is_dot;
  logic                          is_dash;
  logic                          gap_end;
  logic                          word_end;
  logic                          out_free;
  logic                          load_out;
  logic [metd_pkg::CharW-1:0]    out_char;
  logic                          out_last;

  // restoring divide step
  assign trial      = {rem, dvd[metd_pkg::TimeW-1]};
  assign qbit       = (trial >= {1'b0, unit_period_ms});
  assign trial_diff = trial - {1'b0, unit_period_ms};

  // dvd holds the quotient in ST_DECIDE
  assign is_dot   = ~level & (dvd == 32'd1);
  assign is_dash  = ~level & (dvd == 32'd3);
  assign gap_end  = level & (dvd >= 32'd3);
  assign word_end = level & (dvd >= 32'd7);

  assign code_idx = (6'd1 << element_count) | {1'b0, element_bits};
  assign letter   = (!pattern_overflow && element_count != '0)
                    ? metd_pkg::morse_lookup(code_idx) : metd_pkg::NoChar;

  assign out_free = ~m_tvalid | m_tready;

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load_out   = 1'b0;
    out_char   = metd_pkg::AsciiSpace;
    out_last   = 1'b1;
    unique case (state)
      metd_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = metd_pkg::ST_DIV;
        end
      end
      metd_pkg::ST_DIV: begin
        if (step == '1) begin
          state_next = metd_pkg::ST_DECIDE;
        end
      end
      metd_pkg::ST_DECIDE: begin
        if (gap_end && (letter != metd_pkg::NoChar || word_end)) begin
          state_next = metd_pkg::ST_SEND;
        end else begin
          state_next = metd_pkg::ST_IDLE;
        end
      end
      metd_pkg::ST_SEND: begin
        if (out_free) begin
          load_out = 1'b1;
          if (pend_char != metd_pkg::NoChar) begin
            out_char = pend_char;
            out_last = ~pend_space;
            if (!pend_space) begin
              state_next = metd_pkg::ST_IDLE;
            end
          end else begin
            state_next = metd_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = metd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= metd_pkg::ST_IDLE;
      unit_period_ms   <= metd_pkg::UnitReset;
      step             <= '0;
      element_bits     <= '0;
      element_count    <= '0;
      pattern_overflow <= 1'b0;
      pend_char        <= metd_pkg::NoChar;
      pend_space       <= 1'b0;
      m_tvalid         <= 1'b0;
    end else begin
      state <= state_next;

      // out-of-range writes are dropped
      if (cfg_wr_en && cfg_wr_data >= metd_pkg::UnitMin
          && cfg_wr_data <= metd_pkg::UnitMax) begin
        unit_period_ms <= cfg_wr_data;
      end

      if (q_pop) begin
        dvd   <= q_data.elapsed;
        level <= q_data.level;
        rem   <= '0;
        step  <= '0;
      end

      if (state == metd_pkg::ST_DIV) begin
        dvd  <= {dvd[metd_pkg::TimeW-2:0], qbit};
        rem  <= qbit ? trial_diff[metd_pkg::UnitW-1:0] : trial[metd_pkg::UnitW-1:0];
        step <= step + 1'b1;
      end

      if (state == metd_pkg::ST_DECIDE) begin
        if (is_dot || is_dash) begin
          if (element_count < metd_pkg::MaxElems) begin
            element_bits[element_count] <= is_dash;
            element_count               <= element_count + 1'b1;
          end else begin
            pattern_overflow <= 1'b1;
          end
        end
        if (gap_end) begin
          element_bits     <= '0;
          element_count    <= '0;
          pattern_overflow <= 1'b0;
        end
        pend_char  <= letter;
        pend_space <= word_end;
      end

      if (load_out && pend_char != metd_pkg::NoChar) begin
        pend_char <= metd_pkg::NoChar;
      end

      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {1'b0, out_char};
      m_tlast <= out_last;
    end
  end

endmodule

// ===== test/morse_decode_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_decode_checker: result predictor and comparator for the Morse decoder
// Watches the edge, result and unit period ports. It decodes each accepted
// edge request with its own copy of the letter state, queues the expected
// characters, and compares every accepted result against the oldest one.
// ----------------------------------------------------------------------------
module morse_decode_checker
  import metd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic        m_tlast,
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data,
  output int          fail_count,
  output int          pending,
  output int          results_checked,
  output int          edges_taken
);

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             is_last;
  } decoded_t;

  decoded_t expected_chars[$];

  logic [UnitW-1:0]    unit_ms;
  logic [TimeW-1:0]    prev_time;
  logic                seen_edge;
  logic [ElemW-1:0]    elem_bits;
  logic [ElemCntW-1:0] elem_cnt;
  logic                overflow;
  logic [CharW-1:0]    letter_of[64];

  // letter table keyed by (1 << count) | dash bits, element 0 in bit 0
  initial begin
    string symbols;
    string patterns[36];
    logic [5:0] idx;
    symbols  = "ABCDEFGHIJKLMNOPQRSTUVWXYZ1234567890";
    patterns = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
                 ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
                 "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--..",
                 ".----", "..---", "...--", "....-", ".....", "-....", "--...",
                 "---..", "----.", "-----"};
    foreach (letter_of[i]) letter_of[i] = NoChar;
    for (int s = 0; s < 36; s++) begin
      idx = 6'd1 << patterns[s].len();
      for (int i = 0; i < patterns[s].len(); i++)
        if (patterns[s][i] == "-") idx[i] = 1'b1;
      letter_of[idx] = CharW'(symbols[s]);
    end
    fail_count      = 0;
    pending         = 0;
    results_checked = 0;
    edges_taken     = 0;
  end

  task automatic clear_letter();
    elem_bits = '0;
    elem_cnt  = '0;
    overflow  = 1'b0;
  endtask

  task automatic close_letter(output logic [CharW-1:0] ch);
    logic [5:0] idx;
    ch  = NoChar;
    idx = (6'd1 << elem_cnt) | {1'b0, elem_bits};
    if (!overflow && elem_cnt != 0) ch = letter_of[idx];
    clear_letter();
  endtask

  task automatic decode_edge(input logic [TimeW-1:0] now, input logic lvl);
    logic [TimeW-1:0] units;
    logic [CharW-1:0] ch;
    edges_taken++;
    if (!seen_edge) begin
      seen_edge = 1'b1;
      prev_time = now;
      return;
    end
    units     = (now - prev_time) / {22'd0, unit_ms};
    prev_time = now;
    if (!lvl) begin
      // mark ended
      if (units == 1 || units == 3) begin
        if (elem_cnt < MaxElems) begin
          elem_bits[elem_cnt] = (units == 3);
          elem_cnt++;
        end else begin
          overflow = 1'b1;
        end
      end
    end else if (units >= 3) begin
      // gap ended: letter boundary, maybe word boundary
      close_letter(ch);
      if (ch != NoChar) expected_chars.push_back('{ch, units < 7});
      if (units >= 7) expected_chars.push_back('{AsciiSpace, 1'b1});
    end
  endtask

  always @(posedge clk) begin
    decoded_t want;
    if (rst) begin
      unit_ms   = UnitReset;
      prev_time = '0;
      seen_edge = 1'b0;
      clear_letter();
      expected_chars.delete();
    end else begin
      if (cfg_wr_en && cfg_wr_data >= UnitMin && cfg_wr_data <= UnitMax)
        unit_ms = cfg_wr_data;
      if (s_tvalid && s_tready) decode_edge(s_tdata[31:0], s_tdata[32]);
      if (m_tvalid && m_tready) begin
        results_checked++;
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected result, expected none, got char %h last %b",
                   $time, m_tdata, m_tlast);
          fail_count++;
        end else begin
          want = expected_chars.pop_front();
          if (m_tdata !== {1'b0, want.ch} || m_tlast !== want.is_last) begin
            $display("%0t: result mismatch, expected char %h last %b, got char %h last %b",
                     $time, {1'b0, want.ch}, want.is_last, m_tdata, m_tlast);
            fail_count++;
          end
        end
      end
    end
    pending = expected_chars.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for morse_edge_timing_decoder
// Sends timed edge requests: a directed opening, then phases of random
// letters, some malformed, mixed with noise edges, each phase at its own unit
// period and idling mix. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import metd_pkg::*;

  localparam int unsigned WatchdogCycles = 800_000;
  localparam int          PhaseEdges     = 92;
  localparam int          HoldCycles     = 400;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        cfg_wr_en;
  logic [9:0]  cfg_wr_data;

  int fail_count;
  int pending;
  int results_checked;
  int edges_taken;

  int               send_idle_pct = 0;
  int               stall_pct = 0;
  bit               hold_go = 1'b0;
  logic [TimeW-1:0] cur_time;
  logic [UnitW-1:0] unit_now;
  bit               line_high;
  int               items_sent;
  int               unit_settings;

  morse_edge_timing_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  morse_decode_checker decode_check (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tlast         (m_tlast),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .edges_taken     (edges_taken)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(WatchdogCycles * 12);
    $display("%0t: timeout", $time);
    $display("morse_edge_timing_decoder verification failed");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic push_edge(input logic [TimeW-1:0] t, input logic lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, lvl, t};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // next edge k whole units plus off ms after the previous one
  task automatic edge_in(input int k, input int off, input logic lvl);
    cur_time += k * unit_now + off;
    push_edge(cur_time, lvl);
  endtask

  function automatic int jitter();
    return $urandom_range(unit_now - 1);
  endfunction

  task automatic settle();
    int waited;
    s_tvalid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
  endtask

  task automatic write_unit(input logic [UnitW-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (v >= UnitMin && v <= UnitMax) begin
      unit_now = v;
      unit_settings++;
    end
  endtask

  // one letter of n elements; n above five overflows
  task automatic send_letter();
    int         n;
    int         k;
    logic [6:0] dashes;
    n      = ($urandom_range(9) == 0) ? $urandom_range(6, 7) : $urandom_range(1, 5);
    dashes = 7'($urandom);
    if (!line_high) begin
      if ($urandom_range(99) < 8) k = $urandom_range(0, 2);
      else if ($urandom_range(99) < 70) k = $urandom_range(3, 6);
      else k = $urandom_range(7, 11);
      edge_in(k, jitter(), 1'b1);
    end
    for (int i = 0; i < n; i++) begin
      if (i > 0) edge_in(($urandom_range(99) < 5) ? $urandom_range(0, 2) : 1, jitter(), 1'b1);
      k = dashes[i] ? 3 : 1;
      if ($urandom_range(99) < 5) k = $urandom_range(0, 5);
      edge_in(k, jitter(), 1'b0);
    end
    line_high = 1'b0;
  endtask

  task automatic send_noise();
    logic lvl;
    lvl = 1'($urandom_range(1));
    if ($urandom_range(1)) begin
      edge_in($urandom_range(12), jitter(), lvl);
    end else begin
      cur_time += $urandom;
      push_edge(cur_time, lvl);
    end
    line_high = lvl;
  endtask

  initial begin
    int unit_plan[8];
    int phase_start;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    rst         <= 1'b1;
    unit_now      = UnitReset;
    items_sent    = 0;
    unit_settings = 1;
    line_high     = 1'b0;
    unit_plan     = '{1, 1000, 37, 0, 3, 2, 250, 0};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed opening at the reset unit period
    cur_time = 32'hFFFF_FFB0;
    push_edge(cur_time, 1'b1);          // time base only
    edge_in(1, 0, 1'b0);                // dot across the timestamp wrap
    edge_in(7, 0, 1'b1);                // E then space
    edge_in(3, 99, 1'b0);               // dash at top of its unit
    edge_in(3, 0, 1'b1);                // T alone
    for (int i = 0; i < 6; i++) begin   // six dots: overlong letter
      if (i > 0) edge_in(1, 0, 1'b1);
      edge_in(1, 50, 1'b0);
    end
    edge_in(7, 0, 1'b1);                // space only
    edge_in(2, 0, 1'b0);                // odd mark, ignored
    edge_in(9, 99, 1'b1);               // empty letter, space only
    edge_in(1, 0, 1'b0);
    edge_in(2, 50, 1'b1);               // short gap, ignored
    edge_in(3, 0, 1'b0);
    edge_in(6, 99, 1'b1);               // A, longest letter gap
    edge_in(0, 5, 1'b0);                // zero-length mark, ignored
    line_high = 1'b0;

    for (int p = 0; p < 8; p++) begin
      settle();
      case (p % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 78; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 78; end
        default: begin send_idle_pct = 19; stall_pct = 19; end
      endcase
      if (p % 2 == 1) write_unit(($urandom_range(1) != 0) ? 10'd0 : 10'($urandom_range(1001, 1023)));
      write_unit((unit_plan[p] != 0) ? 10'(unit_plan[p]) : 10'($urandom_range(2, 999)));
      if (p == 4) hold_go = 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseEdges) begin
        if ($urandom_range(99) < 75) send_letter();
        else send_noise();
      end
    end

    settle();
    $display("%0d edge requests taken, %0d results checked", edges_taken, results_checked);
    $display("%0d unit periods from 1 to 1000 ms, four idling mixes, one long hold-off",
             unit_settings);
    if (fail_count == 0 && pending == 0) begin
      $display("morse_edge_timing_decoder verification clean");
    end else begin
      if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
      $display("morse_edge_timing_decoder verification failed");
    end
    $finish;
  end

endmodule
